/* rtl/triangle_unit_normal_top_macros.svh */
// Assertion helpers for the triangle normal block.
`ifndef TRIANGLE_UNIT_NORMAL_TOP_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_TOP_MACROS_SVH
`ifndef SYNTHESIS
// plain property on clk with reset disable
`define TUN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// same-cycle implication
`define TUN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define TUN_ASSERT(lbl, prop, msg)
`define TUN_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

/* rtl/tun_pkg.sv */
package tun_pkg;
	localparam int COORD_WIDTH = 16;
	localparam int FRAC_BITS   = 14;
	localparam int OUT_WIDTH   = 16;
	localparam int OUT_MAX     = (2 ** (OUT_WIDTH - 1)) - 1;

	localparam int EDGE_W  = COORD_WIDTH + 1;
	localparam int PROD_W  = 2 * EDGE_W;
	localparam int CROSS_W = PROD_W + 1;
	localparam int MAGN_W  = CROSS_W - 1;
	localparam int MAG_W   = 31;
	localparam int SHIFT_MAX = MAGN_W - MAG_W;
	localparam int SH_W    = $clog2(SHIFT_MAX + 1);
	localparam int SQ_W    = 2 * MAG_W;
	localparam int SUM_W   = SQ_W + 2;
	localparam int ROOT_W  = SUM_W / 2;
	localparam int REM_W   = ROOT_W + 3;
	localparam int QW      = FRAC_BITS + 1;
	localparam int DIVD_W  = MAG_W + FRAC_BITS + 1;

	// per-item sideband through the root pipe
	typedef struct packed {
		logic [2:0][MAG_W-1:0] mag;
		logic [2:0]            neg;
		logic                  degen;
	} side_t;

	// per-item sideband through the divider
	typedef struct packed {
		logic [2:0] neg;
		logic       degen;
	} dside_t;
endpackage

/* rtl/triangle_unit_normal_top.sv */
// Throughput: one triangle per cycle while not frozen; set by the 32-stage
//   root pipe and the 15-stage divider, each a single step per stage.
// The whole pipe freezes while a result waits under nrm_stall.
// Reset (arst_n low, asynchronous) clears all valid bits; data regs keep junk.
`include "triangle_unit_normal_top_macros.svh"

module triangle_unit_normal_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 tri_valid,
	output logic                                 tri_stall,
	input  logic signed [tun_pkg::COORD_WIDTH-1:0] a_x,
	input  logic signed [tun_pkg::COORD_WIDTH-1:0] a_y,
	input  logic signed [tun_pkg::COORD_WIDTH-1:0] a_z,
	input  logic signed [tun_pkg::COORD_WIDTH-1:0] b_x,
	input  logic signed [tun_pkg::COORD_WIDTH-1:0] b_y,
	input  logic signed [tun_pkg::COORD_WIDTH-1:0] b_z,
	input  logic signed [tun_pkg::COORD_WIDTH-1:0] c_x,
	input  logic signed [tun_pkg::COORD_WIDTH-1:0] c_y,
	input  logic signed [tun_pkg::COORD_WIDTH-1:0] c_z,
	output logic                                 nrm_valid,
	input  logic                                 nrm_stall,
	output logic signed [tun_pkg::OUT_WIDTH-1:0] normal_x,
	output logic signed [tun_pkg::OUT_WIDTH-1:0] normal_y,
	output logic signed [tun_pkg::OUT_WIDTH-1:0] normal_z,
	output logic                                 degenerate
);
	import tun_pkg::*;

	// Global advance: every stage moves unless a finished beat is held.
	logic adv;
	logic valid_q;
	assign adv       = !(valid_q && nrm_stall);
	assign tri_stall = !adv;

	// ---------------- s1: edge vectors E = B - A, F = C - A
	logic                     v_s1;
	logic signed [EDGE_W-1:0] ex_s1, ey_s1, ez_s1, fx_s1, fy_s1, fz_s1;

	// ---------------- s2: six partial products of the cross product
	logic                     v_s2;
	logic signed [PROD_W-1:0] p_s2 [0:5];

	// ---------------- s3: cross components as sign + magnitude
	logic                     v_s3;
	logic [2:0][MAGN_W-1:0]   mag_s3;
	logic [2:0]               neg_s3;

	// ---------------- s4: common right shift so the max fits MAG_W bits
	logic                     v_s4;
	side_t                    side_s4;

	// ---------------- s5: squares
	logic                     v_s5;
	logic [SQ_W-1:0]          sq_s5 [0:2];
	side_t                    side_s5;

	// ---------------- s6: sum of squares
	logic                     v_s6;
	logic [SUM_W-1:0]         sum_s6;
	side_t                    side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= tri_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// s3 combinational: N = E x F, then |N| and sign
	logic signed [CROSS_W-1:0] n_c [0:2];
	logic [2:0][MAGN_W-1:0]    mag_c;
	logic [2:0]                neg_c;

	always_comb begin
		n_c[0] = CROSS_W'(p_s2[0]) - CROSS_W'(p_s2[1]);
		n_c[1] = CROSS_W'(p_s2[2]) - CROSS_W'(p_s2[3]);
		n_c[2] = CROSS_W'(p_s2[4]) - CROSS_W'(p_s2[5]);
		for (int i = 0; i < 3; i++) begin
			neg_c[i] = n_c[i][CROSS_W-1];
			mag_c[i] = neg_c[i] ? MAGN_W'(-n_c[i]) : MAGN_W'(n_c[i]);
		end
	end

	// s4 combinational: shift amount from the top bits of the OR of magnitudes
	logic [MAGN_W-1:0] orv_c;
	logic [SH_W-1:0]   sh_c;
	side_t             side_c;

	always_comb begin
		orv_c = mag_s3[0] | mag_s3[1] | mag_s3[2];
		sh_c  = '0;
		for (int k = 0; k < SHIFT_MAX; k++) begin
			if (orv_c[MAG_W + k])
				sh_c = SH_W'(k + 1);
		end
		side_c.neg   = neg_s3;
		side_c.degen = (orv_c == '0);
		for (int i = 0; i < 3; i++)
			side_c.mag[i] = MAG_W'(mag_s3[i] >> sh_c);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ex_s1 <= EDGE_W'(b_x) - EDGE_W'(a_x);
			ey_s1 <= EDGE_W'(b_y) - EDGE_W'(a_y);
			ez_s1 <= EDGE_W'(b_z) - EDGE_W'(a_z);
			fx_s1 <= EDGE_W'(c_x) - EDGE_W'(a_x);
			fy_s1 <= EDGE_W'(c_y) - EDGE_W'(a_y);
			fz_s1 <= EDGE_W'(c_z) - EDGE_W'(a_z);

			p_s2[0] <= PROD_W'(ey_s1) * PROD_W'(fz_s1);
			p_s2[1] <= PROD_W'(ez_s1) * PROD_W'(fy_s1);
			p_s2[2] <= PROD_W'(ez_s1) * PROD_W'(fx_s1);
			p_s2[3] <= PROD_W'(ex_s1) * PROD_W'(fz_s1);
			p_s2[4] <= PROD_W'(ex_s1) * PROD_W'(fy_s1);
			p_s2[5] <= PROD_W'(ey_s1) * PROD_W'(fx_s1);

			mag_s3 <= mag_c;
			neg_s3 <= neg_c;

			side_s4 <= side_c;

			for (int i = 0; i < 3; i++)
				sq_s5[i] <= SQ_W'(side_s4.mag[i]) * SQ_W'(side_s4.mag[i]);
			side_s5 <= side_s4;

			sum_s6  <= SUM_W'(sq_s5[0]) + SUM_W'(sq_s5[1]) + SUM_W'(sq_s5[2]);
			side_s6 <= side_s5;
		end
	end

	// ---------------- s7..s38: floor square root, one root bit per stage
	logic              sq_vld;
	logic [ROOT_W-1:0] len;
	side_t             sq_side;

	tun_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (v_s6),
		.radicand (sum_s6),
		.in_side  (side_s6),
		.out_vld  (sq_vld),
		.root     (len),
		.out_side (sq_side)
	);

	// ---------------- s39: dividend = (mag << FRAC_BITS) + len/2 (round half up)
	logic                   v_s7;
	logic [2:0][DIVD_W-1:0] dvd_s7;
	logic [ROOT_W-1:0]      len_s7;
	dside_t                 dside_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++)
				dvd_s7[i] <= (DIVD_W'(sq_side.mag[i]) << FRAC_BITS) + DIVD_W'(len >> 1);
			len_s7         <= len;
			dside_s7.neg   <= sq_side.neg;
			dside_s7.degen <= sq_side.degen;
		end
	end

	// ---------------- s40..s54: restoring divide, three lanes
	logic               dv_vld;
	logic [2:0][QW-1:0] quot;
	dside_t             dv_side;

	tun_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (v_s7),
		.dividend (dvd_s7),
		.divisor  (len_s7),
		.in_side  (dside_s7),
		.out_vld  (dv_vld),
		.quot     (quot),
		.out_side (dv_side)
	);

	// ---------------- output register: saturate, apply sign, zero if degenerate
	logic signed [OUT_WIDTH-1:0] res_c [0:2];
	logic        [OUT_WIDTH-1:0] mq_c  [0:2];
	logic signed [OUT_WIDTH-1:0] nx_q, ny_q, nz_q;
	logic                        degen_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (32'(quot[i]) > 32'(OUT_MAX))
				mq_c[i] = OUT_WIDTH'(OUT_MAX);
			else
				mq_c[i] = OUT_WIDTH'(quot[i]);
			if (dv_side.degen)
				res_c[i] = '0;
			else if (dv_side.neg[i])
				res_c[i] = -$signed(mq_c[i]);
			else
				res_c[i] = $signed(mq_c[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nx_q    <= res_c[0];
			ny_q    <= res_c[1];
			nz_q    <= res_c[2];
			degen_q <= dv_side.degen;
		end
	end

	assign nrm_valid  = valid_q;
	assign normal_x   = nx_q;
	assign normal_y   = ny_q;
	assign normal_z   = nz_q;
	assign degenerate = degen_q;

	`TUN_ASSERT_IMP(a_degen_zero, nrm_valid && degenerate, normal_x == 0 && normal_y == 0 && normal_z == 0, "degenerate beat with nonzero normal")
	`TUN_ASSERT_IMP(a_x_range, nrm_valid, normal_x <= 16'sd16384 && normal_x >= -16'sd16384, "normal_x out of unit range")
	`TUN_ASSERT_IMP(a_y_range, nrm_valid, normal_y <= 16'sd16384 && normal_y >= -16'sd16384, "normal_y out of unit range")
	`TUN_ASSERT_IMP(a_held_freeze, valid_q && nrm_stall, tri_stall, "pipe not frozen while output held")
endmodule

/* rtl/tun_sqrt.sv */
module tun_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic                        in_vld,
	input  logic [tun_pkg::SUM_W-1:0]   radicand,
	input  tun_pkg::side_t              in_side,
	output logic                        out_vld,
	output logic [tun_pkg::ROOT_W-1:0]  root,
	output tun_pkg::side_t              out_side
);
	import tun_pkg::*;

	// index 0 is the input, index g+1 the register after root bit g
	logic                vld_s  [0:ROOT_W];
	logic [SUM_W-1:0]    rad_s  [0:ROOT_W];
	logic [REM_W-1:0]    rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0]   root_s [0:ROOT_W];
	side_t               side_s [0:ROOT_W];

	assign vld_s[0]  = in_vld;
	assign rad_s[0]  = radicand;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
		logic [REM_W-1:0]  rem_sh, trial, rem_nx;
		logic [ROOT_W-1:0] root_nx;

		always_comb begin
			rem_sh = {rem_s[g][REM_W-3:0], rad_s[g][SUM_W-1:SUM_W-2]};
			trial  = {1'b0, root_s[g], 2'b01};
			if (rem_sh >= trial) begin
				rem_nx  = rem_sh - trial;
				root_nx = {root_s[g][ROOT_W-2:0], 1'b1};
			end else begin
				rem_nx  = rem_sh;
				root_nx = {root_s[g][ROOT_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (adv) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rad_s[g+1]  <= {rad_s[g][SUM_W-3:0], 2'b00};
				rem_s[g+1]  <= rem_nx;
				root_s[g+1] <= root_nx;
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_vld  = vld_s[ROOT_W];
	assign root     = root_s[ROOT_W];
	assign out_side = side_s[ROOT_W];
endmodule

/* rtl/tun_div.sv */
module tun_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  adv,
	input  logic                                  in_vld,
	input  logic [2:0][tun_pkg::DIVD_W-1:0]       dividend,
	input  logic [tun_pkg::ROOT_W-1:0]            divisor,
	input  tun_pkg::dside_t                       in_side,
	output logic                                  out_vld,
	output logic [2:0][tun_pkg::QW-1:0]           quot,
	output tun_pkg::dside_t                       out_side
);
	import tun_pkg::*;

	// three lanes share one divisor; one quotient bit per stage, MSB first
	logic                        vld_s  [0:QW];
	logic [2:0][DIVD_W-1:0]      rem_s  [0:QW];
	logic [2:0][QW-1:0]          q_s    [0:QW];
	logic [ROOT_W-1:0]           dsr_s  [0:QW];
	dside_t                      side_s [0:QW];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = dividend;
	assign q_s[0]    = '0;
	assign dsr_s[0]  = divisor;
	assign side_s[0] = in_side;

	for (genvar g = 0; g < QW; g++) begin : g_stage
		logic [DIVD_W-1:0]      dsh;
		logic [2:0][DIVD_W-1:0] rem_nx;
		logic [2:0][QW-1:0]     q_nx;

		always_comb begin
			dsh = DIVD_W'(dsr_s[g]) << (QW - 1 - g);
			for (int i = 0; i < 3; i++) begin
				if (rem_s[g][i] >= dsh) begin
					rem_nx[i] = rem_s[g][i] - dsh;
					q_nx[i]   = {q_s[g][i][QW-2:0], 1'b1};
				end else begin
					rem_nx[i] = rem_s[g][i];
					q_nx[i]   = {q_s[g][i][QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (adv) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[g+1]  <= rem_nx;
				q_s[g+1]    <= q_nx;
				dsr_s[g+1]  <= dsr_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_vld  = vld_s[QW];
	assign quot     = q_s[QW];
	assign out_side = side_s[QW];
endmodule

/* tb/sv/tun_checker.sv */
module tun_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic tri_valid,
	input  logic tri_stall,
	input  logic signed [tun_pkg::COORD_WIDTH-1:0] a_x, a_y, a_z,
	input  logic signed [tun_pkg::COORD_WIDTH-1:0] b_x, b_y, b_z,
	input  logic signed [tun_pkg::COORD_WIDTH-1:0] c_x, c_y, c_z,
	input  logic nrm_valid,
	input  logic nrm_stall,
	input  logic signed [tun_pkg::OUT_WIDTH-1:0] normal_x, normal_y, normal_z,
	input  logic degenerate,
	output int   errors,
	output int   pending
);
	import tun_pkg::*;

	typedef struct packed {
		logic [OUT_WIDTH-1:0] nx, ny, nz;
		logic                 degen;
	} normal_t;

	normal_t normals_due[$];

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic normal_t face_normal(input logic signed [COORD_WIDTH-1:0] ax, ay, az,
			bx, by, bz, cx, cy, cz);
		logic signed [63:0] ex, ey, ez, fx, fy, fz;
		logic signed [127:0] n [3];
		logic [127:0] m [3];
		logic [2:0] neg;
		logic [63:0] mg, sum, len, q;
		int bl, s;
		normal_t r;
		ex = bx - ax; ey = by - ay; ez = bz - az;
		fx = cx - ax; fy = cy - ay; fz = cz - az;
		n[0] = 128'(ey) * 128'(fz) - 128'(ez) * 128'(fy);
		n[1] = 128'(ez) * 128'(fx) - 128'(ex) * 128'(fz);
		n[2] = 128'(ex) * 128'(fy) - 128'(ey) * 128'(fx);
		bl = 0;
		for (int i = 0; i < 3; i++) begin
			neg[i] = n[i] < 0;
			m[i] = neg[i] ? -n[i] : n[i];
			for (int k = 0; k < 128; k++)
				if (m[i][k] && k + 1 > bl) bl = k + 1;
		end
		r = '0;
		if (bl == 0) begin
			r.degen = 1'b1;
			return r;
		end
		s = bl > MAG_W ? bl - MAG_W : 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			mg = 64'(m[i] >> s);
			sum = sum + mg * mg;
			m[i] = 128'(mg);
		end
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			q = ((m[i][63:0] << FRAC_BITS) + (len >> 1)) / len;
			if (q > OUT_MAX) q = OUT_MAX;
			q = neg[i] ? -q : q;
			if (i == 0) r.nx = q[15:0];
			else if (i == 1) r.ny = q[15:0];
			else r.nz = q[15:0];
		end
		return r;
	endfunction

	assign pending = normals_due.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (tri_valid && !tri_stall)
				normals_due.push_back(face_normal(a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z));
			if (nrm_valid && !nrm_stall) begin
				if (normals_due.size() == 0) begin
					if (errors < 10) $display("unexpected normal beat");
					errors <= errors + 1;
				end else begin
					normal_t e;
					e = normals_due.pop_front();
					if (e !== {normal_x, normal_y, normal_z, degenerate}) begin
						if (errors < 10)
							$display("exp %0d %0d %0d d%0b got %0d %0d %0d d%0b",
								$signed(e.nx), $signed(e.ny), $signed(e.nz), e.degen,
								normal_x, normal_y, normal_z, degenerate);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

/* tb/sv/tb.sv */
module tb;
	import tun_pkg::*;

	logic clk = 0, arst_n = 0;
	logic tri_valid = 0, tri_stall, nrm_valid, nrm_stall = 0, degenerate;
	logic signed [COORD_WIDTH-1:0] a_x = 0, a_y = 0, a_z = 0, b_x = 0, b_y = 0, b_z = 0,
		c_x = 0, c_y = 0, c_z = 0;
	logic signed [OUT_WIDTH-1:0] normal_x, normal_y, normal_z;
	int errors, pending;
	int cycles = 0;
	int send_idle = 16, recv_idle = 79;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	triangle_unit_normal_top i_dut (.*);
	tun_checker i_chk (.*);

	// generous limit: worst stalls times item count plus pipe latency
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("triangle_unit_normal_top: mismatch");
			$finish;
		end
	end

	// receiver stall, random per cycle
	always @(posedge clk) nrm_stall <= ($urandom_range(99) < recv_idle);

	// coordinates: extremes, small, or full random
	function automatic logic [15:0] pick_coord();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(8)) - 16'd4;
			default: return 16'($urandom);
		endcase
	endfunction

	// send one triangle beat; holds until accepted
	task automatic send_tri(input logic [15:0] v [9]);
		while ($urandom_range(99) < send_idle) begin
			tri_valid <= 0;
			@(posedge clk);
		end
		tri_valid <= 1;
		{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} <=
			{v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
		@(posedge clk);
		while (tri_stall) @(posedge clk);
	endtask

	initial begin
		logic [15:0] v [9];
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: zero, collinear, axis aligned, all extremes, plus random picks
		for (int d = 0; d < 20; d++) begin
			for (int k = 0; k < 9; k++) begin
				case (d % 5)
					0: v[k] = 0;
					1: v[k] = 16'(k / 3);
					2: v[k] = (k == 3 || k == 7) ? 16'h7fff : 16'h8000;
					3: v[k] = (k % 4 == 0) ? 16'h7fff : 16'h8000;
					default: v[k] = pick_coord();
				endcase
			end
			if (d == 10) begin
				v = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
					16'h8000, 16'h7fff, 16'h8000};
			end
			send_tri(v);
		end
		for (int n = 0; n < 1350; n++) begin
			if (n == 450) begin
				send_idle = 79;
				recv_idle = 16;
			end
			if (n == 900) begin
				send_idle = 0;
				recv_idle = 0;
			end
			for (int k = 0; k < 9; k++) v[k] = pick_coord();
			// degenerate: repeat a vertex now and then
			if ($urandom_range(19) == 0) for (int k = 0; k < 3; k++) v[3 + k] = v[k];
			send_tri(v);
		end
		tri_valid <= 0;
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("triangle_unit_normal_top: match");
		else
			$display("triangle_unit_normal_top: mismatch");
		$finish;
	end
endmodule

/* files.f */
+incdir+rtl
rtl/tun_pkg.sv
rtl/tun_sqrt.sv
rtl/tun_div.sv
rtl/triangle_unit_normal_top.sv
tb/sv/tun_checker.sv
tb/sv/tb.sv
